@@ rtl/core/sce_pkg.sv @@
// Package for the string character escaper: escape descriptor type,
// character constants and helper functions for run length and run characters.
// No dependencies.
`timescale 1ns / 1ps

package sce_pkg;

	localparam int unsigned IdxW = 3;

	localparam logic [7:0] ChBslash = 8'h5C;
	localparam logic [7:0] ChQuote  = 8'h22;
	localparam logic [7:0] ChZero   = 8'h30;
	localparam logic [7:0] ChSeven  = 8'h37;
	localparam logic [7:0] ChUpperA = 8'h41;
	localparam logic [7:0] ChLowU   = 8'h75;
	localparam logic [7:0] ChLowX   = 8'h78;
	localparam logic [7:0] ChLowB   = 8'h62;
	localparam logic [7:0] ChLowT   = 8'h74;
	localparam logic [7:0] ChLowN   = 8'h6E;
	localparam logic [7:0] ChLowV   = 8'h76;
	localparam logic [7:0] ChLowF   = 8'h66;
	localparam logic [7:0] ChLowR   = 8'h72;
	localparam logic [7:0] CtrlLimit = 8'd32;
	localparam logic [7:0] DelChar   = 8'd127;

	// escape form chosen by the classifier
	typedef enum logic [1:0] {
		KIND_PASS   = 2'd0,  // byte as is
		KIND_LETTER = 2'd1,  // backslash + data
		KIND_HEX_X  = 2'd2,  // backslash x H L
		KIND_HEX_U  = 2'd3   // backslash u 0 0 H L
	} esc_kind_t;

	typedef struct packed {
		esc_kind_t  kind;
		logic [7:0] data;
	} esc_desc_t;

	function automatic logic [IdxW-1:0] desc_len(input esc_desc_t d);
		logic [IdxW-1:0] n;
		case (d.kind)
			KIND_PASS:   n = 3'd1;
			KIND_LETTER: n = 3'd2;
			KIND_HEX_X:  n = 3'd4;
			KIND_HEX_U:  n = 3'd6;
			default:     n = 3'd1;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		logic [7:0] ch;
		if (nib < 4'd10) begin
			ch = ChZero + {4'd0, nib};
		end else begin
			ch = ChUpperA + {4'd0, nib} - 8'd10;
		end
		return ch;
	endfunction

	function automatic logic [7:0] run_char(input esc_desc_t d, input logic [IdxW-1:0] idx);
		logic [7:0] ch;
		ch = ChBslash;
		case (d.kind)
			KIND_PASS: ch = d.data;
			KIND_LETTER: begin
				if (idx == 3'd1) ch = d.data;
			end
			KIND_HEX_X: begin
				case (idx)
					3'd1:    ch = ChLowX;
					3'd2:    ch = hex_digit(d.data[7:4]);
					3'd3:    ch = hex_digit(d.data[3:0]);
					default: ch = ChBslash;
				endcase
			end
			KIND_HEX_U: begin
				case (idx)
					3'd1:    ch = ChLowU;
					3'd2:    ch = ChZero;
					3'd3:    ch = ChZero;
					3'd4:    ch = hex_digit(d.data[7:4]);
					3'd5:    ch = hex_digit(d.data[3:0]);
					default: ch = ChBslash;
				endcase
			end
			default: ch = d.data;
		endcase
		return ch;
	endfunction

endpackage

@@ rtl/core/sce_front.sv @@
// Front end: accepts input bytes, classifies each into an escape descriptor
// and holds it in one register stage. Depends on sce_pkg.
`timescale 1ns / 1ps

module sce_front import sce_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       json_mode,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_in,
	input  logic [7:0] next_char,
	output logic       desc_valid,
	input  logic       desc_ready,
	output esc_desc_t  desc
);

	logic       vld_s1;
	esc_desc_t  desc_s1;
	esc_desc_t  desc_c;
	logic [7:0] letter;
	logic       next_is_oct;

	always_comb begin
		case (char_in)
			8'h08:   letter = ChLowB;
			8'h09:   letter = ChLowT;
			8'h0A:   letter = ChLowN;
			8'h0B:   letter = json_mode ? 8'd0 : ChLowV;
			8'h0C:   letter = ChLowF;
			8'h0D:   letter = ChLowR;
			ChBslash: letter = ChBslash;
			ChQuote: letter = ChQuote;
			default: letter = 8'd0;
		endcase
	end

	assign next_is_oct = (next_char >= ChZero) && (next_char <= ChSeven);

	always_comb begin
		if (letter != 8'd0) begin
			desc_c.kind = KIND_LETTER;
			desc_c.data = letter;
		end else if (char_in < 8'd8 && !json_mode && !next_is_oct) begin
			desc_c.kind = KIND_LETTER;
			desc_c.data = ChZero + char_in;
		end else if (char_in < CtrlLimit || char_in >= DelChar) begin
			desc_c.kind = json_mode ? KIND_HEX_U : KIND_HEX_X;
			desc_c.data = char_in;
		end else begin
			desc_c.kind = KIND_PASS;
			desc_c.data = char_in;
		end
	end

	assign in_ready = !vld_s1 || desc_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	// payload: hold while stalled
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			desc_s1 <= desc_c;
		end
	end

	assign desc_valid = vld_s1;
	assign desc       = desc_s1;

endmodule

@@ rtl/core/sce_queue.sv @@
// Short descriptor queue between front end and back end, register based.
// Depends on sce_pkg.
`timescale 1ns / 1ps

module sce_queue import sce_pkg::*; #(
	parameter int unsigned QDEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  esc_desc_t push_desc,
	output logic      pop_valid,
	input  logic      pop,
	output esc_desc_t head
);

	localparam int unsigned PtrW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned CntW = $clog2(QDEPTH + 1);

	esc_desc_t       mem_q [QDEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (count_q != CntW'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

endmodule

@@ rtl/core/sce_back.sv @@
// Back end: walks the head descriptor into the output register one character per cycle
// while that register is free, and pops it with its last character. Depends on sce_pkg.
`timescale 1ns / 1ps

module sce_back import sce_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  esc_desc_t  q_head,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       last
);

	logic [IdxW-1:0] idx_q;
	logic            out_valid_q;
	logic [7:0]      out_char_q;
	logic            last_q;
	logic            out_free;
	logic            emit;
	logic            at_end;
	logic [IdxW-1:0] len;

	assign len      = desc_len(q_head);
	assign out_free = !out_valid_q || out_ready;
	assign emit     = q_valid && out_free;
	assign at_end   = (idx_q == len - 1'b1);
	assign q_pop    = emit && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= q_valid;
			end
			if (emit) begin
				idx_q <= at_end ? '0 : idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q <= run_char(q_head, idx_q);
			last_q     <= at_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign last      = last_q;

	// run position never runs past the head's length
	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid |-> (idx_q < len))
		else $error("run index past descriptor length");

	// a descriptor leaves the queue only with its marked final character
	a_pop_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (out_valid_q && last_q))
		else $error("descriptor popped without final character");

	// with nothing queued the walk sits at the start of a run
	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!q_valid |-> (idx_q == '0))
		else $error("run index nonzero with empty queue");

endmodule

@@ rtl/core/string_char_escaper.sv @@
// String character escaper: one byte in, an escape run of 1, 2, 4 or 6
// characters out, with the final character marked.
// Path from input transaction to first output character: front register, queue entry,
// then output register. Throughput: one output character per cycle while out_ready allows,
// so plain bytes go at one per cycle while out_ready allows; the input stalls once the queue
// and the front register are full.
// Reset: clears all valid flags, queue pointers, run index and json_style (script mode).
`timescale 1ns / 1ps

module string_char_escaper import sce_pkg::*; #(
	parameter int unsigned QDEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_in,
	input  logic [7:0] next_char,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       last
);

	logic      json_style_q;
	logic      f_valid;
	logic      f_ready;
	esc_desc_t f_desc;
	logic      q_valid;
	logic      q_pop;
	esc_desc_t q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			json_style_q <= 1'b0;
		end else if (cfg_valid) begin
			json_style_q <= cfg_data;
		end
	end

	sce_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.json_mode  (json_style_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.char_in    (char_in),
		.next_char  (next_char),
		.desc_valid (f_valid),
		.desc_ready (f_ready),
		.desc       (f_desc)
	);

	sce_queue #(.QDEPTH(QDEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_desc  (f_desc),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.head       (q_head)
	);

	sce_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_char  (out_char),
		.last      (last)
	);

endmodule
